@@ rtl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the matrix multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication property checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ rtl/mm4_pkg.sv @@
// Types and constants of the fixed-point matrix multiplier.
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int VALUE_W = 32;
  localparam int PROD_W  = 2 * VALUE_W;
  localparam int IDX_W   = 2;

  // Operation codes of an input item.
  localparam logic [1:0] OP_WR_FIRST  = 2'd0;
  localparam logic [1:0] OP_WR_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE   = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          row;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_col;
    logic [IDX_W-1:0]          out_row;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  // Control bits that travel with each product element down the chain.
  typedef struct packed {
    logic valid;
    logic last;
  } tok_ctl_t;

endpackage

@@ rtl/matrix_multiply_4x4.sv @@
// A compute item's elements run from the sequencer through the two-stage cells of the chain
// and the output register. Throughput: write items are taken one per cycle while idle; a
// compute item then emits DIM*DIM results one per cycle unless out_ready stalls the chain,
// and the block takes no item until the last one is delivered.
// Reset: rst_n clears the sequencer and token valid bits; matrix contents are kept.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IW    = $clog2(DIM);
  localparam int SUM_W = PROD_W - FRAC_BITS + IW + 1;
  localparam logic [IW-1:0] IDX_MAX = IW'(DIM - 1);

  logic adv;
  logic in_acc;
  logic out_acc;
  logic in_range;

  // Sequencer state.
  logic          busy_r;
  logic          issuing_r;
  logic [IW-1:0] c_r;
  logic [IW-1:0] r_r;

  // Write bus to the cells.
  logic                      wr_first;
  logic                      wr_second;
  logic [IW-1:0]             wr_col;
  logic [IW-1:0]             wr_row;

  // Links of the chain.
  tok_ctl_t                  ctl_chain [DIM+1];
  logic [IW-1:0]             c_chain   [DIM+1];
  logic [IW-1:0]             r_chain   [DIM+1];
  logic signed [SUM_W-1:0]   sum_chain [DIM+1];

  // Output register.
  logic      out_valid_r;
  out_item_t out_item_r;
  logic signed [SUM_W-1:0]   end_sum;
  logic [VALUE_W-1:0]        sat_value;

  assign in_ready = !busy_r;
  assign in_acc   = in_valid && !busy_r;
  assign out_acc  = out_valid_r && out_ready;
  // The whole chain moves whenever the output register can take an item.
  assign adv      = !out_valid_r || out_ready;

  // Writes outside the matrix are dropped.
  assign in_range = (32'(in_item.col) < 32'(DIM)) && (32'(in_item.row) < 32'(DIM));
  assign wr_first  = in_acc && in_range && in_item.op == OP_WR_FIRST;
  assign wr_second = in_acc && in_range && in_item.op == OP_WR_SECOND;
  assign wr_col    = IW'(in_item.col);
  assign wr_row    = IW'(in_item.row);

  // Sequencer: issue one product element per advancing cycle, column then row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      c_r       <= '0;
      r_r       <= '0;
    end else begin
      if (in_acc && in_item.op == OP_COMPUTE) begin
        busy_r    <= 1'b1;
        issuing_r <= 1'b1;
        c_r       <= '0;
        r_r       <= '0;
      end else if (issuing_r && adv) begin
        if (r_r == IDX_MAX) begin
          r_r <= '0;
          if (c_r == IDX_MAX) begin
            issuing_r <= 1'b0;
          end else begin
            c_r <= c_r + 1'b1;
          end
        end else begin
          r_r <= r_r + 1'b1;
        end
      end
      if (out_acc && out_item_r.last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Head of the chain.
  assign ctl_chain[0].valid = issuing_r;
  assign ctl_chain[0].last  = issuing_r && c_r == IDX_MAX && r_r == IDX_MAX;
  assign c_chain[0]         = c_r;
  assign r_chain[0]         = r_r;
  assign sum_chain[0]       = '0;

  for (genvar k = 0; k < DIM; k++) begin : g_cell
    mm4_cell #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS),
      .IDX       (k),
      .IW        (IW),
      .SUM_W     (SUM_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .wr_first  (wr_first),
      .wr_second (wr_second),
      .wr_col    (wr_col),
      .wr_row    (wr_row),
      .wr_data   (in_item.value),
      .in_ctl    (ctl_chain[k]),
      .in_c      (c_chain[k]),
      .in_r      (r_chain[k]),
      .in_sum    (sum_chain[k]),
      .out_ctl   (ctl_chain[k+1]),
      .out_c     (c_chain[k+1]),
      .out_r     (r_chain[k+1]),
      .out_sum   (sum_chain[k+1])
    );
  end

  // Saturate the finished sum to 32 bits: in range when the upper bits agree.
  assign end_sum = sum_chain[DIM];
  always_comb begin
    if (&end_sum[SUM_W-1:VALUE_W-1] || ~|end_sum[SUM_W-1:VALUE_W-1]) begin
      sat_value = end_sum[VALUE_W-1:0];
    end else if (end_sum[SUM_W-1]) begin
      sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_chain[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.out_col   <= IDX_W'(c_chain[DIM]);
      out_item_r.out_row   <= IDX_W'(r_chain[DIM]);
      out_item_r.out_value <= sat_value;
      out_item_r.last      <= ctl_chain[DIM].last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Results appear only while a compute item is in flight.
  `ASSERT_IMPL(a_out_only_busy, clk, rst_n, out_valid |-> !in_ready, "result while idle")
  // Delivering the last element frees the block for the next item.
  `ASSERT_IMPL(a_last_frees, clk, rst_n,
               (out_valid && out_ready && out_item.last) |=> in_ready, "not freed after last")
  // The sequencer never issues outside a compute.
  `ASSERT_NEVER(a_issue_busy, clk, rst_n, issuing_r && !busy_r, "issue while idle")

endmodule

@@ rtl/mm4_cell.sv @@
// One cell of the multiply-accumulate chain: holds column IDX of the first
// matrix and row IDX of the second, and adds one product term to the sum.
`timescale 1ns / 1ps

module mm4_cell
  import mm4_pkg::*;
#(
  parameter int DIM       = 4,
  parameter int FRAC_BITS = 16,
  parameter int IDX       = 0,
  parameter int IW        = 2,
  parameter int SUM_W     = 51
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      wr_first,
  input  logic                      wr_second,
  input  logic [IW-1:0]             wr_col,
  input  logic [IW-1:0]             wr_row,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  tok_ctl_t                  in_ctl,
  input  logic [IW-1:0]             in_c,
  input  logic [IW-1:0]             in_r,
  input  logic signed [SUM_W-1:0]   in_sum,
  output tok_ctl_t                  out_ctl,
  output logic [IW-1:0]             out_c,
  output logic [IW-1:0]             out_r,
  output logic signed [SUM_W-1:0]   out_sum
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Local slices of both matrices: first[IDX][r] and second[c][IDX].
  logic signed [VALUE_W-1:0] a_mem [DIM];
  logic signed [VALUE_W-1:0] b_mem [DIM];

  // Stage A registers: product and the delayed token.
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_d_r;
  tok_ctl_t                 ctl_a_r;
  logic [IW-1:0]            c_a_r;
  logic [IW-1:0]            r_a_r;

  // Stage B registers: accumulated sum handed to the next cell.
  tok_ctl_t                 ctl_b_r;
  logic [IW-1:0]            c_b_r;
  logic [IW-1:0]            r_b_r;
  logic signed [SUM_W-1:0]  sum_b_r;

  logic signed [SUM_W-1:0]  term;

  // Element writes into the local slices.
  always_ff @(posedge clk) begin
    if (wr_first && wr_col == MY_IDX) begin
      a_mem[wr_row] <= wr_data;
    end
    if (wr_second && wr_row == MY_IDX) begin
      b_mem[wr_col] <= wr_data;
    end
  end

  // Stage A: read both operands and multiply.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= PROD_W'(a_mem[in_r]) * PROD_W'(b_mem[in_c]);
      sum_d_r <= in_sum;
      c_a_r   <= in_c;
      r_a_r   <= in_r;
    end
  end

  // Arithmetic shift floors the product; the result always fits SUM_W.
  assign term = SUM_W'(prod_r >>> FRAC_BITS);

  // Stage B: add this cell's term to the running sum.
  always_ff @(posedge clk) begin
    if (adv) begin
      sum_b_r <= sum_d_r + term;
      c_b_r   <= c_a_r;
      r_b_r   <= r_a_r;
    end
  end

  // Token control bits are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (adv) begin
      ctl_a_r <= in_ctl;
      ctl_b_r <= ctl_a_r;
    end
  end

  assign out_ctl = ctl_b_r;
  assign out_c   = c_b_r;
  assign out_r   = r_b_r;
  assign out_sum = sum_b_r;

endmodule
